/* rtl/core/gaa_pkg.sv */
// ----------------------------------------------------------------------------
// gaa_pkg
// shared widths, command and register codes, and the parent entry layout
// ----------------------------------------------------------------------------
package gaa_pkg;

	localparam int MAX_FEATURES_DEF = 4096;
	localparam int MAX_PARENTS_DEF  = 1024;

	localparam int CMD_W     = 2;
	localparam int FEATURE_W = 12;
	localparam int PARENT_W  = 10;
	localparam int ANGLE_W   = 16;
	localparam int SUM_W     = 32;
	localparam int BCOUNT_W  = 13;
	localparam int UCOUNT_W  = 16;

	localparam int S_DATA_W  = 56;
	localparam int M_DATA_W  = 72;

	localparam int CFG_INDEX_W = 2;

	localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PAIR = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] REG_BIASED   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_UNBIASED = 2'd1;

	// divider: numerator 2*sum+count, denominator 2*count
	localparam int DIV_NUM_W  = SUM_W + 2;
	localparam int DIV_DEN_W  = UCOUNT_W + 1;
	localparam int DIV_REM_W  = DIV_DEN_W + 1;
	localparam int DIV_STEP_W = $clog2(DIV_NUM_W + 1);

	typedef struct packed {
		logic [UCOUNT_W-1:0] ucnt;
		logic [SUM_W-1:0]    usum;
		logic [BCOUNT_W-1:0] bcnt;
		logic [SUM_W-1:0]    bsum;
	} parent_entry_t;

endpackage

/* rtl/core/gaa_ram.sv */
// ----------------------------------------------------------------------------
// gaa_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module gaa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/gaa_div.sv */
// ----------------------------------------------------------------------------
// gaa_div
// bit-serial rounded mean: (2*sum+count)/(2*count), clamped to 16 bits
// ----------------------------------------------------------------------------
module gaa_div import gaa_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [SUM_W-1:0]    sum,
	input  logic [UCOUNT_W-1:0] cnt,
	output logic                done,
	output logic [ANGLE_W-1:0]  quot
);

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_STEP_W-1:0] step_q;
	logic [DIV_NUM_W-1:0]  num_q;
	logic [DIV_DEN_W-1:0]  den_q;
	logic [DIV_REM_W-1:0]  rem_q;
	logic [DIV_NUM_W-1:0]  quo_q;
	logic                  zero_q;

	logic [DIV_REM_W-1:0]  rem_sh;
	logic                  fits;

	assign rem_sh = {rem_q[DIV_REM_W-2:0], num_q[DIV_NUM_W-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= DIV_STEP_W'(DIV_NUM_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == DIV_STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= {1'b0, sum, 1'b0} + DIV_NUM_W'(cnt);
			den_q  <= {cnt, 1'b0};
			rem_q  <= '0;
			quo_q  <= '0;
			zero_q <= cnt == '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_NUM_W-2:0], 1'b0};
			if (fits) begin
				rem_q <= rem_sh - {1'b0, den_q};
				quo_q <= {quo_q[DIV_NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[DIV_NUM_W-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (zero_q) begin
			quot = '0;
		end else if (quo_q[DIV_NUM_W-1:ANGLE_W] != '0) begin
			quot = '1;
		end else begin
			quot = quo_q[ANGLE_W-1:0];
		end
	end

	assign done = done_q;

endmodule

/* rtl/core/grouped_average_accumulator_top.sv */
// ----------------------------------------------------------------------------
// grouped_average_accumulator_top
// per-parent biased and unbiased misalignment means over a feature parent table
//
// channel   dir  handshake          payload
// s         in   s_tvalid/s_tready  s_tuser cmd, s_tdata feature/parent/neighbor/angle
// m         out  m_tvalid/m_tready  m_tdata parent, averages, counts
// cfg       in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// load feature: feature table write, then with biased mode on a parent ram read-modify-write
// neighbor pair: two feature table reads then the parent update
// read and clear: two passes of the 34-step serial divider
// after reset the parent ram is zeroed, one entry a cycle
// a pending result waits in the output register; only a read waits on it
// ----------------------------------------------------------------------------
module grouped_average_accumulator_top import gaa_pkg::*; #(
	parameter int MAX_FEATURES = MAX_FEATURES_DEF,
	parameter int MAX_PARENTS  = MAX_PARENTS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [S_DATA_W-1:0]    s_tdata,   // feature_index, parent_id, neighbor_index, angle_value
	input  logic [CMD_W-1:0]       s_tuser,   // cmd
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [M_DATA_W-1:0]    m_tdata,   // read_parent, biased_average, unbiased_average,
	                                          // member_count, pair_count
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic                   cfg_data
);

	localparam int FAW = $clog2(MAX_FEATURES);
	localparam int PAW = $clog2(MAX_PARENTS);
	localparam int EW  = $bits(parent_entry_t);

	typedef enum logic [8:0] {
		ST_CLEAR    = 9'b000000001,
		ST_IDLE     = 9'b000000010,
		ST_PAIR_NB  = 9'b000000100,
		ST_PAIR_CMP = 9'b000001000,
		ST_ACC      = 9'b000010000,
		ST_RD       = 9'b000100000,
		ST_DIV_B    = 9'b001000000,
		ST_DIV_U    = 9'b010000000,
		ST_EMIT     = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_d;

	logic [PAW-1:0]       clr_q;
	logic                 biased_en_q;
	logic                 unbiased_en_q;
	logic                 m_valid_q;
	logic [M_DATA_W-1:0]  m_data_q;

	logic [PAW-1:0]       addr_q;
	logic [PARENT_W-1:0]  p1_q;
	logic [FEATURE_W-1:0] nb_q;
	logic [ANGLE_W-1:0]   val_q;
	logic                 acc_biased_q;
	logic [PARENT_W-1:0]  par_q;
	logic [BCOUNT_W-1:0]  bcnt_q;
	logic [UCOUNT_W-1:0]  ucnt_q;
	logic [SUM_W-1:0]     usum_q;
	logic [ANGLE_W-1:0]   bavg_q;
	logic [ANGLE_W-1:0]   uavg_q;

	logic [CMD_W-1:0]     in_cmd;
	logic [FEATURE_W-1:0] in_feat;
	logic [PARENT_W-1:0]  in_par;
	logic [FEATURE_W-1:0] in_nb;
	logic [ANGLE_W-1:0]   in_val;
	logic                 accept;
	logic                 feat_ok;
	logic                 nb_ok;
	logic                 par_ok;
	logic                 emit_go;

	logic                 ft_we;
	logic [FAW-1:0]       ft_raddr;
	logic [PARENT_W-1:0]  ft_rdata;

	logic                 pm_we;
	logic [PAW-1:0]       pm_waddr;
	logic [PAW-1:0]       pm_raddr;
	parent_entry_t        pm_wdata;
	logic [EW-1:0]        pm_rdata_raw;
	parent_entry_t        pm_rdata;
	parent_entry_t        acc_entry;
	logic [SUM_W:0]       sum_ext;
	logic [SUM_W-1:0]     sum_new;

	logic                 div_start;
	logic [SUM_W-1:0]     div_sum;
	logic [UCOUNT_W-1:0]  div_cnt;
	logic                 div_done;
	logic [ANGLE_W-1:0]   div_q;

	assign in_cmd  = s_tuser;
	assign in_feat = s_tdata[11:0];
	assign in_par  = s_tdata[21:12];
	assign in_nb   = s_tdata[33:22];
	assign in_val  = s_tdata[49:34];

	assign s_tready = state_q == ST_IDLE;
	assign accept   = s_tvalid && s_tready;
	assign feat_ok  = (in_feat != '0) && (32'(in_feat) < 32'(MAX_FEATURES));
	assign nb_ok    = (in_nb != '0) && (32'(in_nb) < 32'(MAX_FEATURES));
	assign par_ok   = 32'(in_par) < 32'(MAX_PARENTS);
	assign emit_go  = (state_q == ST_EMIT) && (!m_valid_q || m_tready);

	// feature parent table
	assign ft_we    = accept && (in_cmd == CMD_LOAD) && feat_ok && par_ok;
	assign ft_raddr = (state_q == ST_PAIR_NB) ? FAW'(nb_q) : FAW'(in_feat);

	gaa_ram #(
		.WIDTH (PARENT_W),
		.DEPTH (MAX_FEATURES)
	) u_ft_ram (
		.clk   (clk),
		.we    (ft_we),
		.waddr (FAW'(in_feat)),
		.wdata (in_par),
		.raddr (ft_raddr),
		.rdata (ft_rdata)
	);

	// parent sums and counts
	assign pm_rdata = parent_entry_t'(pm_rdata_raw);
	assign pm_raddr = (state_q == ST_PAIR_CMP) ? PAW'(p1_q) : PAW'(in_par);

	assign sum_ext = {1'b0, (acc_biased_q ? pm_rdata.bsum : pm_rdata.usum)}
		+ (SUM_W+1)'(val_q);
	assign sum_new = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];

	always_comb begin
		acc_entry = pm_rdata;
		if (acc_biased_q) begin
			acc_entry.bsum = sum_new;
			if (pm_rdata.bcnt != '1) begin
				acc_entry.bcnt = pm_rdata.bcnt + 1'b1;
			end
		end else begin
			acc_entry.usum = sum_new;
			if (pm_rdata.ucnt != '1) begin
				acc_entry.ucnt = pm_rdata.ucnt + 1'b1;
			end
		end
	end

	always_comb begin
		pm_we    = 1'b0;
		pm_waddr = addr_q;
		pm_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				pm_we    = 1'b1;
				pm_waddr = clr_q;
			end
			ST_ACC: begin
				pm_we    = 1'b1;
				pm_wdata = acc_entry;
			end
			ST_RD: begin
				pm_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	gaa_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_PARENTS)
	) u_pm_ram (
		.clk   (clk),
		.we    (pm_we),
		.waddr (pm_waddr),
		.wdata (EW'(pm_wdata)),
		.raddr (pm_raddr),
		.rdata (pm_rdata_raw)
	);

	// shared divider: biased mean first, then unbiased
	assign div_start = (state_q == ST_RD) || ((state_q == ST_DIV_B) && div_done);
	assign div_sum   = (state_q == ST_RD) ? pm_rdata.bsum : usum_q;
	assign div_cnt   = (state_q == ST_RD) ? UCOUNT_W'(pm_rdata.bcnt) : ucnt_q;

	gaa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.sum    (div_sum),
		.cnt    (div_cnt),
		.done   (div_done),
		.quot   (div_q)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == PAW'(MAX_PARENTS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					unique case (in_cmd)
						CMD_LOAD: begin
							if (feat_ok && par_ok && biased_en_q) begin
								state_d = ST_ACC;
							end
						end
						CMD_PAIR: begin
							if (feat_ok && nb_ok && unbiased_en_q) begin
								state_d = ST_PAIR_NB;
							end
						end
						CMD_READ: begin
							state_d = par_ok ? ST_RD : ST_EMIT;
						end
						default: begin
						end
					endcase
				end
			end
			ST_PAIR_NB: begin
				state_d = ST_PAIR_CMP;
			end
			ST_PAIR_CMP: begin
				if ((ft_rdata == p1_q) && (32'(p1_q) < 32'(MAX_PARENTS))) begin
					state_d = ST_ACC;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_ACC: begin
				state_d = ST_IDLE;
			end
			ST_RD: begin
				state_d = ST_DIV_B;
			end
			ST_DIV_B: begin
				if (div_done) begin
					state_d = ST_DIV_U;
				end
			end
			ST_DIV_U: begin
				if (div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (emit_go) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_q         <= '0;
			biased_en_q   <= 1'b1;
			unbiased_en_q <= 1'b1;
			m_valid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_BIASED:   biased_en_q   <= cfg_data;
					REG_UNBIASED: unbiased_en_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (emit_go) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q <= in_val;
			nb_q  <= in_nb;
			par_q <= in_par;
			if (in_cmd == CMD_LOAD) begin
				addr_q       <= PAW'(in_par);
				acc_biased_q <= 1'b1;
			end else if (in_cmd == CMD_READ) begin
				addr_q <= PAW'(in_par);
				bavg_q <= '0;
				uavg_q <= '0;
				bcnt_q <= '0;
				ucnt_q <= '0;
			end
		end
		if (state_q == ST_PAIR_NB) begin
			p1_q <= ft_rdata;
		end
		if (state_q == ST_PAIR_CMP) begin
			addr_q       <= PAW'(p1_q);
			acc_biased_q <= 1'b0;
		end
		if (state_q == ST_RD) begin
			bcnt_q <= pm_rdata.bcnt;
			ucnt_q <= pm_rdata.ucnt;
			usum_q <= pm_rdata.usum;
		end
		if ((state_q == ST_DIV_B) && div_done) begin
			bavg_q <= div_q;
		end
		if ((state_q == ST_DIV_U) && div_done) begin
			uavg_q <= div_q;
		end
		if (emit_go) begin
			m_data_q <= {1'b0, ucnt_q, bcnt_q, uavg_q, bavg_q, par_q};
		end
	end

	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;
	assign cfg_ready = 1'b1;

endmodule

/* rtl/core/gaa_checker.sv */
// ----------------------------------------------------------------------------
// gaa_checker
// port-level checks on the result stream of the grouped average accumulator
// ----------------------------------------------------------------------------
module gaa_checker import gaa_pkg::*; #(
	parameter int MAX_PARENTS = MAX_PARENTS_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic [CMD_W-1:0]    s_tuser,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata
);

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// only a read transaction starts a result
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser != CMD_READ) |=> !$rose(m_tvalid))
		else $error("result without read transaction");

	// out-of-range parent reads report zeros
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (32'(m_tdata[9:0]) >= 32'(MAX_PARENTS)) |-> (m_tdata[70:10] == '0))
		else $error("out-of-range read with nonzero fields");

	// empty biased group gives zero mean
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[54:42] == '0) |-> (m_tdata[25:10] == '0))
		else $error("biased mean nonzero with zero count");

	// empty unbiased group gives zero mean
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[70:55] == '0) |-> (m_tdata[41:26] == '0))
		else $error("unbiased mean nonzero with zero count");

endmodule

bind grouped_average_accumulator_top gaa_checker #(
	.MAX_PARENTS (MAX_PARENTS)
) u_gaa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

/* tb/grouped_average_accumulator_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grouped_average_accumulator_top_tb
// stream-level check of the per-parent mean accumulator
//
// A queue of samples feeds a falling-edge driver with random gaps. A monitor
// at the rising edge keeps a shadow parent table with saturating sums and
// counts, and queues the averages that each read owes. Output transactions
// are compared field by field against that queue. The run covers directed
// corner cases, random traffic under every enable setting, a long receiver
// stall, and a back-to-back burst.
// ----------------------------------------------------------------------------
module grouped_average_accumulator_top_tb;
	import gaa_pkg::*;

	localparam int N_FEATURES = MAX_FEATURES_DEF;
	localparam int N_PARENTS  = MAX_PARENTS_DEF;
	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
	localparam logic [BCOUNT_W-1:0] MEMBER_MAX = '1;
	localparam logic [UCOUNT_W-1:0] PAIR_MAX   = '1;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [CMD_W-1:0]     cmd;
		logic [FEATURE_W-1:0] feature;
		logic [PARENT_W-1:0]  parent;
		logic [FEATURE_W-1:0] neighbor;
		logic [ANGLE_W-1:0]   angle;
	} sample_t;

	typedef struct packed {
		logic [PARENT_W-1:0] parent;
		logic [ANGLE_W-1:0]  biased;
		logic [ANGLE_W-1:0]  unbiased;
		logic [BCOUNT_W-1:0] members;
		logic [UCOUNT_W-1:0] pairs;
	} averages_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [S_DATA_W-1:0]    s_tdata = '0;
	logic [CMD_W-1:0]       s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b1;
	logic [M_DATA_W-1:0]    m_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic                   cfg_data = 1'b0;

	grouped_average_accumulator_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// shadow state
	logic [PARENT_W-1:0] parent_of [N_FEATURES];
	logic [SUM_W-1:0]    bias_sum  [N_PARENTS];
	logic [BCOUNT_W-1:0] bias_cnt  [N_PARENTS];
	logic [SUM_W-1:0]    pair_sum  [N_PARENTS];
	logic [UCOUNT_W-1:0] pair_cnt  [N_PARENTS];
	logic                biased_on = 1'b1;
	logic                pairs_on = 1'b1;

	sample_t   outgoing_samples [$];
	averages_t owed_averages [$];

	int pushed_count = 0;
	int s_offered = 0;
	int s_accepted = 0;
	int results_seen = 0;
	int reads_sent = 0;
	int reg_writes = 0;
	int mismatches = 0;
	int hold_requests = 0;
	int holds_served = 0;
	logic tight = 1'b0;

	// stimulus bookkeeping: features whose parent entry has been written
	int known_feats [$];
	int loaded_parent [int];
	int parent_pool [18];

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		$display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] a,
			input logic [ANGLE_W-1:0] b);
		logic [SUM_W:0] t;
		t = {1'b0, a} + b;
		return t[SUM_W] ? '1 : t[SUM_W-1:0];
	endfunction

	function automatic logic [ANGLE_W-1:0] rounded_mean(input logic [SUM_W-1:0] s,
			input logic [31:0] c);
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] q;
		if (c == 0) begin
			return '0;
		end
		num = {32'd0, s} * 64'd2 + {32'd0, c};
		den = {32'd0, c} * 64'd2;
		q = num / den;
		return (q > 64'hFFFF) ? '1 : q[ANGLE_W-1:0];
	endfunction

	task automatic accumulate_sample(input sample_t it);
		logic [PARENT_W-1:0] p;
		averages_t r;
		case (it.cmd)
			CMD_LOAD: begin
				if (it.feature != 0 && it.feature < N_FEATURES && it.parent < N_PARENTS) begin
					p = it.parent;
					parent_of[it.feature] = p;
					if (biased_on) begin
						bias_sum[p] = sat_sum(bias_sum[p], it.angle);
						if (bias_cnt[p] != MEMBER_MAX)
							bias_cnt[p] = bias_cnt[p] + 1'b1;
					end
				end
			end
			CMD_PAIR: begin
				if (it.feature != 0 && it.neighbor != 0 && pairs_on) begin
					p = parent_of[it.feature];
					if (p == parent_of[it.neighbor]) begin
						pair_sum[p] = sat_sum(pair_sum[p], it.angle);
						if (pair_cnt[p] != PAIR_MAX)
							pair_cnt[p] = pair_cnt[p] + 1'b1;
					end
				end
			end
			CMD_READ: begin
				p = it.parent;
				r.parent   = p;
				r.biased   = rounded_mean(bias_sum[p], 32'(bias_cnt[p]));
				r.unbiased = rounded_mean(pair_sum[p], 32'(pair_cnt[p]));
				r.members  = bias_cnt[p];
				r.pairs    = pair_cnt[p];
				owed_averages.push_back(r);
				bias_sum[p] = '0;
				bias_cnt[p] = '0;
				pair_sum[p] = '0;
				pair_cnt[p] = '0;
			end
			default: begin
			end
		endcase
	endtask

	// input side monitor and predictor
	sample_t seen_sample;
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			seen_sample.cmd      = s_tuser;
			seen_sample.feature  = s_tdata[11:0];
			seen_sample.parent   = s_tdata[21:12];
			seen_sample.neighbor = s_tdata[33:22];
			seen_sample.angle    = s_tdata[49:34];
			accumulate_sample(seen_sample);
			s_accepted++;
		end
	end

	// output side monitor
	averages_t got_avg;
	averages_t want_avg;
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_avg.parent   = m_tdata[9:0];
			got_avg.biased   = m_tdata[25:10];
			got_avg.unbiased = m_tdata[41:26];
			got_avg.members  = m_tdata[54:42];
			got_avg.pairs    = m_tdata[70:55];
			results_seen++;
			if (owed_averages.size() == 0) begin
				flag_mismatch("result with nothing owed, parent", got_avg.parent, 0);
			end else begin
				want_avg = owed_averages.pop_front();
				if (got_avg.parent != want_avg.parent)
					flag_mismatch("read_parent", got_avg.parent, want_avg.parent);
				if (got_avg.biased != want_avg.biased)
					flag_mismatch("biased_average", got_avg.biased, want_avg.biased);
				if (got_avg.unbiased != want_avg.unbiased)
					flag_mismatch("unbiased_average", got_avg.unbiased, want_avg.unbiased);
				if (got_avg.members != want_avg.members)
					flag_mismatch("member_count", got_avg.members, want_avg.members);
				if (got_avg.pairs != want_avg.pairs)
					flag_mismatch("pair_count", got_avg.pairs, want_avg.pairs);
			end
		end
	end

	// sender
	int gap;
	int gap_left = 0;
	int calm_left = 0;
	sample_t next_sample;

	task automatic offer_next();
		next_sample = outgoing_samples.pop_front();
		s_tdata  <= {6'd0, next_sample.angle, next_sample.neighbor, next_sample.parent,
			next_sample.feature};
		s_tuser  <= next_sample.cmd;
		s_tvalid <= 1'b1;
		s_offered++;
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_accepted == s_offered) begin
				if (calm_left > 0) begin
					calm_left--;
				end else if ($urandom_range(0, 15) == 0) begin
					calm_left = $urandom_range(8, 40);
				end
				gap = (tight || calm_left > 0) ? 0 : $urandom_range(0, 7);
				if (gap == 0 && outgoing_samples.size() != 0) begin
					offer_next();
				end else begin
					s_tvalid <= 1'b0;
					gap_left = gap;
				end
			end else if (!s_tvalid) begin
				if (gap_left > 0)
					gap_left--;
				else if (outgoing_samples.size() != 0)
					offer_next();
			end
		end
	end

	// receiver
	int hold_left = 0;
	int rx_wait = 0;
	int results_paced = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_requests != holds_served) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (results_seen != results_paced) begin
				results_paced = results_seen;
				rx_wait = $urandom_range(0, 7);
				m_tready <= (rx_wait == 0);
			end else if (rx_wait > 0) begin
				rx_wait--;
				m_tready <= (rx_wait == 0);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic push_sample(input logic [CMD_W-1:0] c, input int f, input int p,
			input int n, input int v);
		sample_t it;
		it.cmd      = c;
		it.feature  = f[FEATURE_W-1:0];
		it.parent   = p[PARENT_W-1:0];
		it.neighbor = n[FEATURE_W-1:0];
		it.angle    = v[ANGLE_W-1:0];
		if (c == CMD_LOAD && it.feature != 0) begin
			if (!loaded_parent.exists(f))
				known_feats.push_back(f);
			loaded_parent[f] = p;
		end
		if (c == CMD_READ)
			reads_sent++;
		outgoing_samples.push_back(it);
		pushed_count++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (s_accepted != pushed_count || owed_averages.size() != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic val);
		@(negedge clk);
		cfg_index = idx;
		cfg_data  = val;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_BIASED)
			biased_on = val;
		else if (idx == REG_UNBIASED)
			pairs_on = val;
		reg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
		@(posedge clk);
	endtask

	function automatic int pick_angle();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return 0;
		if (roll == 1)
			return 16'hFFFF;
		return $urandom_range(0, 16'hFFFF);
	endfunction

	function automatic int pick_parent();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, N_PARENTS - 1);
		return parent_pool[$urandom_range(0, 17)];
	endfunction

	function automatic int pick_known();
		return known_feats[$urandom_range(0, known_feats.size() - 1)];
	endfunction

	task automatic push_random_sample();
		int roll;
		int f;
		int n;
		int cands [$];
		roll = $urandom_range(0, 99);
		if (roll < 40) begin
			f = ($urandom_range(0, 1) == 0) ? pick_known() : $urandom_range(1, N_FEATURES - 1);
			push_sample(CMD_LOAD, f, pick_parent(), $urandom_range(0, 4095), pick_angle());
		end else if (roll < 75) begin
			f = pick_known();
			n = pick_known();
			if ($urandom_range(0, 9) < 7) begin
				foreach (known_feats[i])
					if (loaded_parent[known_feats[i]] == loaded_parent[f])
						cands.push_back(known_feats[i]);
				n = cands[$urandom_range(0, cands.size() - 1)];
			end
			push_sample(CMD_PAIR, f, $urandom_range(0, 1023), n, pick_angle());
		end else if (roll < 90) begin
			push_sample(CMD_READ, $urandom_range(0, 4095), pick_parent(),
				$urandom_range(0, 4095), $urandom_range(0, 16'hFFFF));
		end else begin
			case ($urandom_range(0, 3))
				0: push_sample(CMD_SPARE, $urandom_range(0, 4095), $urandom_range(0, 1023),
					$urandom_range(0, 4095), $urandom_range(0, 16'hFFFF));
				1: push_sample(CMD_LOAD, 0, pick_parent(), $urandom_range(0, 4095),
					pick_angle());
				2: push_sample(CMD_PAIR, 0, $urandom_range(0, 1023), pick_known(),
					pick_angle());
				default: push_sample(CMD_PAIR, pick_known(), $urandom_range(0, 1023), 0,
					pick_angle());
			endcase
		end
	endtask

	initial begin
		#40ms;
		$display("timeout with %0d of %0d samples taken", s_accepted, pushed_count);
		$display("RESULT: ERROR");
		$finish;
	end

	logic bias_plan [5] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
	logic pair_plan [5] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
	int guard;

	initial begin
		foreach (parent_of[i])
			parent_of[i] = '0;
		foreach (bias_sum[i]) begin
			bias_sum[i] = '0;
			bias_cnt[i] = '0;
			pair_sum[i] = '0;
			pair_cnt[i] = '0;
		end
		parent_pool[0] = 0;
		parent_pool[1] = N_PARENTS - 1;
		for (int i = 2; i < 18; i++)
			parent_pool[i] = $urandom_range(1, N_PARENTS - 2);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed corners with reset settings
		push_sample(CMD_READ, 0, 0, 0, 0);
		push_sample(CMD_LOAD, 1, 0, 0, 0);
		push_sample(CMD_LOAD, 4095, 1023, 4095, 16'hFFFF);
		push_sample(CMD_LOAD, 2, 1023, 0, 1);
		push_sample(CMD_LOAD, 0, 5, 0, 16'h1234);
		push_sample(CMD_PAIR, 4095, 0, 2, 16'hFFFF);
		push_sample(CMD_PAIR, 2, 1023, 4095, 0);
		push_sample(CMD_PAIR, 1, 0, 4095, 7);
		push_sample(CMD_PAIR, 0, 0, 1, 9);
		push_sample(CMD_PAIR, 1, 0, 0, 9);
		push_sample(CMD_PAIR, 1, 0, 1, 5);
		push_sample(CMD_SPARE, 4095, 1023, 4095, 16'hFFFF);
		push_sample(CMD_LOAD, 3, 512, 0, 3);
		push_sample(CMD_LOAD, 5, 512, 0, 4);
		push_sample(CMD_PAIR, 3, 0, 5, 1);
		push_sample(CMD_PAIR, 5, 0, 3, 2);
		push_sample(CMD_READ, 4095, 1023, 4095, 16'hFFFF);
		push_sample(CMD_READ, 0, 512, 0, 0);
		push_sample(CMD_READ, 0, 1023, 0, 0);
		push_sample(CMD_READ, 0, 0, 0, 0);
		wait_idle();

		// both modes off: parent table still updated, sums untouched
		write_reg(REG_BIASED, 1'b0);
		write_reg(REG_UNBIASED, 1'b0);
		push_sample(CMD_LOAD, 6, 7, 0, 100);
		push_sample(CMD_PAIR, 6, 0, 6, 50);
		push_sample(CMD_READ, 0, 7, 0, 0);
		wait_idle();

		for (int chunk = 0; chunk < 5; chunk++) begin
			write_reg(REG_BIASED, bias_plan[chunk]);
			write_reg(REG_UNBIASED, pair_plan[chunk]);
			if (chunk == 0) begin
				// receiver stalls while reads pile up behind the output register
				hold_requests++;
				for (int i = 0; i < 30; i++)
					push_sample(CMD_READ, 0, pick_parent(), 0, 0);
			end
			repeat (230) push_random_sample();
			wait_idle();
		end

		// back-to-back burst with both modes on
		tight = 1'b1;
		write_reg(REG_BIASED, 1'b1);
		write_reg(REG_UNBIASED, 1'b1);
		repeat (40) push_random_sample();
		wait_idle();
		tight = 1'b0;

		guard = 0;
		while ((s_accepted != pushed_count || owed_averages.size() != 0) && guard < 100000) begin
			@(negedge clk);
			guard++;
		end
		repeat (100) @(negedge clk);
		if (s_accepted != pushed_count)
			flag_mismatch("samples never taken", pushed_count - s_accepted, 0);
		if (owed_averages.size() != 0)
			flag_mismatch("reads never answered", owed_averages.size(), 0);

		$display("%0d input transactions (%0d reads), %0d results checked, %0d register writes",
			s_accepted, reads_sent, results_seen, reg_writes);
		$display("all enable settings, long output stall and a back-to-back burst exercised");
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
